@@ src/spa_pkg.sv @@
// Shared types and constants for the slot pool allocator.
`default_nettype none
package spa_pkg;

    localparam int INDEX_W = 12;
    localparam int DATA_W  = 64;
    localparam int COUNT_W = 13;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_FREE = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef enum logic [2:0] {
        K_NOP,
        K_ADD,
        K_READ,
        K_FREE,
        K_RANGE
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [INDEX_W-1:0]   idx;
        logic [DATA_W-1:0]    data;
        logic                 has_data;
    } item_t;

endpackage
`default_nettype wire

@@ src/spa_front.sv @@
// Front end: decodes the opcode and range-checks the slot index of reads and frees.
`default_nettype none
module spa_front #(
    parameter int SLOTS = 16
) (
    input  wire logic [1:0]                 op,
    input  wire logic [spa_pkg::INDEX_W-1:0] slot_index,
    input  wire logic [spa_pkg::DATA_W-1:0]  slot_data,
    input  wire logic                       has_data,
    output spa_pkg::item_t                  item
);

    logic in_range;

    assign in_range = {1'b0, slot_index} < (spa_pkg::INDEX_W + 1)'(SLOTS);

    always_comb
    begin
        item.idx      = slot_index;
        item.data     = slot_data;
        item.has_data = has_data;
        unique case (op)
            spa_pkg::OP_ADD:  item.kind = spa_pkg::K_ADD;
            spa_pkg::OP_READ: item.kind = in_range ? spa_pkg::K_READ : spa_pkg::K_RANGE;
            spa_pkg::OP_FREE: item.kind = in_range ? spa_pkg::K_FREE : spa_pkg::K_RANGE;
            default:          item.kind = spa_pkg::K_NOP;
        endcase
    end

endmodule
`default_nettype wire

@@ src/spa_queue.sv @@
// Short FIFO of decoded items between the front end and the back end.
`default_nettype none
module spa_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  spa_pkg::item_t      push_item,
    output logic                not_full,
    input  wire logic           pop,
    output logic                not_empty,
    output spa_pkg::item_t      head_item
);

    spa_pkg::item_t                 mem [spa_pkg::QUEUE_DEPTH];
    logic [spa_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [spa_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [spa_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign not_full  = count_reg != spa_pkg::QCNT_W'(spa_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == spa_pkg::QPTR_W'(spa_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == spa_pkg::QPTR_W'(spa_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule
`default_nettype wire

@@ src/spa_back.sv @@
// Back end: free-index stack, slot store, counters and the result register.
`default_nettype none
module spa_back #(
    parameter int SLOTS      = 16,
    parameter int SLOT_WIDTH = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_valid,
    input  spa_pkg::item_t                   q_item,
    output logic                             q_pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [1:0]                       status,
    output logic [spa_pkg::INDEX_W-1:0]      given_index,
    output logic [spa_pkg::DATA_W-1:0]       read_data,
    output logic [spa_pkg::COUNT_W-1:0]      in_use_count
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_POP_WAIT,
        S_READ_WAIT
    } state_t;

    logic [SLOT_WIDTH-1:0] slot_mem  [SLOTS];
    logic [IDX_W-1:0]      stack_mem [SLOTS];

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      depth_reg, depth_next;
    logic [CNT_W-1:0]      fresh_reg, fresh_next;
    logic [CNT_W-1:0]      used_reg, used_next;
    logic [IDX_W-1:0]      clr_reg, clr_next;
    logic [SLOT_WIDTH-1:0] wdata_reg, wdata_next;

    logic                        out_valid_reg, out_valid_next;
    logic [1:0]                  status_reg, status_next;
    logic [spa_pkg::INDEX_W-1:0] given_reg, given_next;
    logic [spa_pkg::DATA_W-1:0]  rdata_reg, rdata_next;
    logic [spa_pkg::COUNT_W-1:0] count_reg, count_next;

    logic [SLOT_WIDTH-1:0] store_rdata_reg;
    logic [IDX_W-1:0]      stack_rdata_reg;

    logic                  take;
    logic                  res_valid;
    logic                  store_we, store_re, stack_we, stack_re;
    logic [IDX_W-1:0]      store_addr;
    logic [SLOT_WIDTH-1:0] store_wdata;
    logic [IDX_W-1:0]      idx_s;
    logic [SLOT_WIDTH-1:0] add_word;

    assign idx_s    = q_item.idx[IDX_W-1:0];
    assign add_word = q_item.has_data ? q_item.data[SLOT_WIDTH-1:0] : '0;
    assign take     = (state_reg == S_IDLE) && q_valid && (!out_valid_reg || out_ready);
    assign q_pop    = take;

    always_comb
    begin
        state_next  = state_reg;
        depth_next  = depth_reg;
        fresh_next  = fresh_reg;
        used_next   = used_reg;
        clr_next    = clr_reg;
        wdata_next  = wdata_reg;
        res_valid   = 1'b0;
        status_next = spa_pkg::ST_OK;
        given_next  = '0;
        rdata_next  = '0;
        store_we    = 1'b0;
        store_re    = 1'b0;
        stack_we    = 1'b0;
        stack_re    = 1'b0;
        store_addr  = idx_s;
        store_wdata = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // zero the slot store once after reset, one entry per cycle
                store_we    = 1'b1;
                store_addr  = clr_reg;
                store_wdata = '0;
                if (clr_reg == IDX_W'(SLOTS - 1))
                    state_next = S_IDLE;
                else
                    clr_next = clr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (take)
                begin
                    unique case (q_item.kind)
                        spa_pkg::K_ADD:
                        begin
                            if (depth_reg != '0)
                            begin
                                stack_re   = 1'b1;
                                wdata_next = add_word;
                                state_next = S_POP_WAIT;
                            end
                            else if (fresh_reg < CNT_W'(SLOTS))
                            begin
                                store_we    = 1'b1;
                                store_addr  = fresh_reg[IDX_W-1:0];
                                store_wdata = add_word;
                                fresh_next  = fresh_reg + 1'b1;
                                used_next   = used_reg + 1'b1;
                                given_next  = spa_pkg::INDEX_W'(fresh_reg);
                                res_valid   = 1'b1;
                            end
                            else
                            begin
                                status_next = spa_pkg::ST_FULL;
                                res_valid   = 1'b1;
                            end
                        end
                        spa_pkg::K_READ:
                        begin
                            store_re   = 1'b1;
                            state_next = S_READ_WAIT;
                        end
                        spa_pkg::K_FREE:
                        begin
                            if (depth_reg >= fresh_reg)
                            begin
                                status_next = spa_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                stack_we   = 1'b1;
                                store_we   = 1'b1;
                                depth_next = depth_reg + 1'b1;
                                if (used_reg != '0)
                                    used_next = used_reg - 1'b1;
                            end
                            res_valid = 1'b1;
                        end
                        spa_pkg::K_RANGE:
                        begin
                            status_next = spa_pkg::ST_RANGE;
                            res_valid   = 1'b1;
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_POP_WAIT:
            begin
                store_we    = 1'b1;
                store_addr  = stack_rdata_reg;
                store_wdata = wdata_reg;
                depth_next  = depth_reg - 1'b1;
                used_next   = used_reg + 1'b1;
                given_next  = spa_pkg::INDEX_W'(stack_rdata_reg);
                res_valid   = 1'b1;
                state_next  = S_IDLE;
            end
            S_READ_WAIT:
            begin
                rdata_next = spa_pkg::DATA_W'(store_rdata_reg);
                res_valid  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        count_next     = spa_pkg::COUNT_W'(used_next);
        out_valid_next = res_valid ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            depth_reg     <= '0;
            fresh_reg     <= '0;
            used_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            fresh_reg     <= fresh_next;
            used_reg      <= used_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wdata_reg <= wdata_next;
        if (res_valid)
        begin
            status_reg <= status_next;
            given_reg  <= given_next;
            rdata_reg  <= rdata_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            slot_mem[store_addr] <= store_wdata;
        if (store_re)
            store_rdata_reg <= slot_mem[idx_s];
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[depth_reg[IDX_W-1:0]] <= idx_s;
        if (stack_re)
            stack_rdata_reg <= stack_mem[IDX_W'(depth_reg - 1'b1)];
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign given_index  = given_reg;
    assign read_data    = rdata_reg;
    assign in_use_count = count_reg;

`ifndef SYNTHESIS
    a_count_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg + depth_reg) == fresh_reg)
        else $error("used count plus free stack depth differs from fresh counter");

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= CNT_W'(SLOTS))
        else $error("fresh counter beyond pool size");

    a_busy_output_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("multi-cycle item running while a result waits");

    a_wait_completes: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_POP_WAIT) || (state_reg == S_READ_WAIT))
        |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("wait state did not deliver its result");
`endif

endmodule
`default_nettype wire

@@ src/slot_pool_allocator.sv @@
// Slot pool allocator: free-index stack and slot store behind an item queue.
//
// Input channel (in_valid/in_ready) carries op, slot_index, slot_data and
// has_data; output channel (out_valid/out_ready) returns one result per item:
// status, given_index, read_data and in_use_count.
// An accepted item lands in a two-entry queue; the back end takes it once it
// is idle and its result register is free or being read. No-op, free, range
// errors, full pool and adds of never-used indices register their result in
// the cycle they are taken; reads and adds that reuse a freed index first pass
// a wait state for the registered read of the slot store or of the free stack.
// Sustained rate: 1 item per cycle for single-step items while out_ready stays
// high; the back end handles one item at a time.
// Reset clears the counters and out_valid, then the back end zeroes the slot
// store entry by entry; up to two items queue up meanwhile and in_ready drops
// until the clearing pass ends.
// When the receiver stalls, the result register holds, the back end stops,
// the queue fills with up to two items and then in_ready drops.
`default_nettype none
module slot_pool_allocator #(
    parameter int SLOTS      = 16,
    parameter int SLOT_WIDTH = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    op,
    input  wire logic [spa_pkg::INDEX_W-1:0]   slot_index,
    input  wire logic [spa_pkg::DATA_W-1:0]    slot_data,
    input  wire logic                          has_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         status,
    output logic [spa_pkg::INDEX_W-1:0]        given_index,
    output logic [spa_pkg::DATA_W-1:0]         read_data,
    output logic [spa_pkg::COUNT_W-1:0]        in_use_count
);

    spa_pkg::item_t front_item;
    spa_pkg::item_t head_item;
    logic           q_not_full;
    logic           q_not_empty;
    logic           q_pop;

    assign in_ready = q_not_full;

    spa_front #(
        .SLOTS      (SLOTS)
    ) u_front (
        .op         (op),
        .slot_index (slot_index),
        .slot_data  (slot_data),
        .has_data   (has_data),
        .item       (front_item)
    );

    spa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid && q_not_full),
        .push_item  (front_item),
        .not_full   (q_not_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head_item  (head_item)
    );

    spa_back #(
        .SLOTS        (SLOTS),
        .SLOT_WIDTH   (SLOT_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_not_empty),
        .q_item       (head_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .given_index  (given_index),
        .read_data    (read_data),
        .in_use_count (in_use_count)
    );

endmodule
`default_nettype wire

@@ tb/sv/slot_pool_checker.sv @@
// Result checker for the slot pool allocator: predicts each item's result and compares.
module slot_pool_checker
    import spa_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int SLOT_WIDTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         op,
    input  logic [INDEX_W-1:0] slot_index,
    input  logic [DATA_W-1:0]  slot_data,
    input  logic               has_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         status,
    input  logic [INDEX_W-1:0] given_index,
    input  logic [DATA_W-1:0]  read_data,
    input  logic [COUNT_W-1:0] in_use_count,
    output int                 pending_results,
    output int                 mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_IDX_W = $clog2(SLOTS);
    localparam logic [DATA_W-1:0] WORD_MASK = {DATA_W{1'b1}} >> (DATA_W - SLOT_WIDTH);

    typedef struct packed {
        logic [1:0]         status;
        logic [INDEX_W-1:0] given;
        logic [DATA_W-1:0]  rdata;
        logic [COUNT_W-1:0] count;
    } pool_result_t;

    // shadow of the pool
    logic [DATA_W-1:0]     slot_mem [SLOTS];
    logic [SLOT_IDX_W-1:0] free_list [SLOTS];
    int unsigned           list_depth;
    int unsigned           next_fresh;
    int unsigned           live_count;

    pool_result_t expected_results [$];
    int           results_seen;

    initial begin
        pending_results = 0;
        mismatches      = 0;
        results_seen    = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < 30)
            $display("%t mismatch on result %0d: %s got %0h expected %0h",
                     $realtime, results_seen, what, got, want);
        mismatches++;
    endtask

    function automatic pool_result_t pool_step(input logic [1:0] cmd,
                                               input logic [INDEX_W-1:0] idx,
                                               input logic [DATA_W-1:0] word,
                                               input logic with_data);
        pool_result_t res;
        int unsigned  slot;
        bit           got;
        res = '0;
        res.status = ST_OK;
        case (cmd)
            OP_ADD:
            begin
                got  = 1'b1;
                slot = 0;
                if (list_depth > 0 && list_depth <= SLOTS) begin
                    list_depth--;
                    slot = free_list[list_depth];
                end else if (next_fresh < SLOTS) begin
                    slot = next_fresh;
                    next_fresh++;
                end else begin
                    got        = 1'b0;
                    res.status = ST_FULL;
                end
                if (got) begin
                    slot_mem[slot] = with_data ? (word & WORD_MASK) : '0;
                    live_count++;
                    res.given = INDEX_W'(slot);
                end
            end
            OP_READ:
            begin
                if (idx >= SLOTS)
                    res.status = ST_RANGE;
                else
                    res.rdata = slot_mem[idx];
            end
            OP_FREE:
            begin
                if (idx >= SLOTS) begin
                    res.status = ST_RANGE;
                end else if (list_depth >= next_fresh || list_depth >= SLOTS) begin
                    // nothing left to free: stack would outgrow handed-out indices
                    res.status = ST_OVERFLOW;
                end else begin
                    free_list[list_depth] = SLOT_IDX_W'(idx);
                    list_depth++;
                    if (live_count > 0)
                        live_count--;
                    slot_mem[idx] = '0;
                end
            end
            default:
            begin
            end
        endcase
        res.count = COUNT_W'(live_count);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        pool_result_t want;
        if (!rst_n) begin
            foreach (slot_mem[i])
                slot_mem[i] = '0;
            foreach (free_list[i])
                free_list[i] = '0;
            list_depth = 0;
            next_fresh = 0;
            live_count = 0;
            expected_results.delete();
            pending_results <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing pending", {62'd0, status}, 64'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", {62'd0, status}, {62'd0, want.status});
                    if (given_index !== want.given)
                        report_mismatch("given_index", 64'(given_index), 64'(want.given));
                    if (read_data !== want.rdata)
                        report_mismatch("read_data", read_data, want.rdata);
                    if (in_use_count !== want.count)
                        report_mismatch("in_use_count", 64'(in_use_count), 64'(want.count));
                end
                results_seen++;
            end
            if (in_valid && in_ready)
                expected_results.push_back(pool_step(op, slot_index, slot_data, has_data));
            pending_results <= expected_results.size();
        end
    end

endmodule

@@ tb/sv/slot_pool_allocator_test.sv @@
// Testbench top for the slot pool allocator: stimulus, stalls and final verdict.
module slot_pool_allocator_test;
    import spa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_SLOTS   = 16;
    localparam int POOL_WIDTH   = 64;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 200_000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         op = OP_NOP;
    logic [INDEX_W-1:0] slot_index = '0;
    logic [DATA_W-1:0]  slot_data = '0;
    logic               has_data = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic [INDEX_W-1:0] given_index;
    logic [DATA_W-1:0]  read_data;
    logic [COUNT_W-1:0] in_use_count;

    logic idle_on = 1'b1;
    int   pending_results;
    int   mismatches;
    int   cycle_count = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    slot_pool_allocator #(
        .SLOTS      (POOL_SLOTS),
        .SLOT_WIDTH (POOL_WIDTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .slot_index   (slot_index),
        .slot_data    (slot_data),
        .has_data     (has_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .given_index  (given_index),
        .read_data    (read_data),
        .in_use_count (in_use_count)
    );

    slot_pool_checker #(
        .SLOTS      (POOL_SLOTS),
        .SLOT_WIDTH (POOL_WIDTH)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .slot_index      (slot_index),
        .slot_data       (slot_data),
        .has_data        (has_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .given_index     (given_index),
        .read_data       (read_data),
        .in_use_count    (in_use_count),
        .pending_results (pending_results),
        .mismatches      (mismatches)
    );

    // receiver stalls
    always @(posedge clk)
        out_ready <= !(idle_on && $urandom_range(0, 99) < 9);

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic issue_request(input logic [1:0] cmd, input logic [INDEX_W-1:0] idx,
                                 input logic [DATA_W-1:0] word, input logic with_data);
        while (idle_on && $urandom_range(0, 99) < 9) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= cmd;
        slot_index <= idx;
        slot_data  <= word;
        has_data   <= with_data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    function automatic logic [INDEX_W-1:0] pick_index();
        if ($urandom_range(0, 99) < 85)
            return INDEX_W'($urandom_range(0, POOL_SLOTS - 1));
        return INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        int         mode;
        int         roll;
        logic [1:0] cmd;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pool: zero store, free with nothing handed out, bad indices, no-op
        issue_request(OP_READ, 12'd0, '1, 1'b1);
        issue_request(OP_FREE, 12'd0, '0, 1'b0);
        issue_request(OP_READ, 12'hFFF, '1, 1'b1);
        issue_request(OP_FREE, 12'hFFF, '0, 1'b0);
        issue_request(OP_FREE, 12'd16, '0, 1'b1);
        issue_request(OP_NOP, 12'hFFF, '1, 1'b1);
        // fresh indices, with and without data
        issue_request(OP_ADD, 12'hFFF, '1, 1'b1);
        issue_request(OP_ADD, 12'd0, '1, 1'b0);
        issue_request(OP_ADD, 12'd0, '0, 1'b1);
        issue_request(OP_ADD, 12'd5, 64'h8000_0000_0000_0001, 1'b1);
        issue_request(OP_READ, 12'd0, '0, 1'b0);
        issue_request(OP_READ, 12'd1, '0, 1'b0);
        issue_request(OP_READ, 12'd3, '0, 1'b0);
        // freed indices come back last-in first-out
        issue_request(OP_FREE, 12'd1, '0, 1'b0);
        issue_request(OP_FREE, 12'd3, '0, 1'b0);
        issue_request(OP_ADD, 12'd0, 64'h0123_4567_89AB_CDEF, 1'b1);
        issue_request(OP_ADD, 12'd0, 64'hFEDC_BA98_7654_3210, 1'b1);
        issue_request(OP_READ, 12'd3, '0, 1'b0);
        issue_request(OP_READ, 12'd1, '0, 1'b0);
        // free everything, then one more free overflows
        issue_request(OP_FREE, 12'd0, '0, 1'b0);
        issue_request(OP_FREE, 12'd1, '0, 1'b0);
        issue_request(OP_FREE, 12'd2, '0, 1'b0);
        issue_request(OP_FREE, 12'd3, '0, 1'b0);
        issue_request(OP_FREE, 12'd2, '0, 1'b0);
        wait_for_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 400)
                wait_for_results();
            if (n == 700)
                idle_on <= 1'b0;
            if (n == 1000)
                idle_on <= 1'b1;
            // fill, mixed, drain, mixed: reaches both a full pool and free overflow
            mode = (n / 100) % 4;
            roll = $urandom_range(0, 99);
            case (mode)
                0: cmd = roll < 70 ? OP_ADD : roll < 85 ? OP_READ : roll < 95 ? OP_FREE : OP_NOP;
                2: cmd = roll < 65 ? OP_FREE : roll < 85 ? OP_READ : roll < 95 ? OP_ADD : OP_NOP;
                default:
                   cmd = roll < 35 ? OP_ADD : roll < 65 ? OP_READ : roll < 95 ? OP_FREE : OP_NOP;
            endcase
            issue_request(cmd, pick_index(), pick_word(), $urandom_range(0, 3) != 0);
        end

        wait_for_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
